[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the ternary weight unpack block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TWUS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("twus assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define TWUS_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("twus forbidden condition seen");

`endif

[sv/twus_pkg.sv]
// ----------------------------------------------------------------------------
// twus_pkg
// Types and fixed constants of the ternary weight unpack and scale block.
// ----------------------------------------------------------------------------
package twus_pkg;

	localparam int WORD_W    = 32;	// packed lane word
	localparam int LANE_W    = 8;	// int8 lane scale
	localparam int PAGE_W    = 16;	// Q8.8 page scale
	localparam int CNT_W     = 5;	// valid column count
	localparam int COL_W     = 5;	// column offset
	localparam int TRIT_W    = 2;	// signed trit
	localparam int WEIGHT_W  = 17;	// Q9.8 weight
	localparam int DIG_W     = 2;	// base-3 digit

	// page * lane fits 24 bits signed, magnitude at most 2^22
	localparam int PROD_W    = 24;
	localparam int MAG_W     = 23;

	// serial divide by 127
	localparam int REM_W     = 7;
	localparam int DIV_STEPS = MAG_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);
	localparam logic [REM_W:0] DIVISOR = 8'd127;

	// base-3 digit codes
	localparam logic [DIG_W-1:0] DIG_ZERO = 2'd0;
	localparam logic [DIG_W-1:0] DIG_POS  = 2'd1;
	localparam logic [DIG_W-1:0] DIG_NEG  = 2'd2;

	// decoded trit values
	localparam logic signed [TRIT_W-1:0] TRIT_ZERO = 2'sd0;
	localparam logic signed [TRIT_W-1:0] TRIT_POS  = 2'sd1;
	localparam logic signed [TRIT_W-1:0] TRIT_NEG  = -2'sd1;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// divider status and result
	typedef struct packed {
		logic                       done;
		logic signed [WEIGHT_W-1:0] mag;
	} div_res_t;

endpackage

[sv/twus_div127.sv]
// ----------------------------------------------------------------------------
// twus_div127
// Bit-serial restoring divide of a signed product by 127, truncating
// toward zero. One quotient bit per cycle, sign applied as a final step.
// ----------------------------------------------------------------------------
module twus_div127 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [twus_pkg::PROD_W-1:0]  prod,
	output twus_pkg::div_res_t                  res
);

	logic                                 busy_q;
	logic                                 done_q;
	logic [twus_pkg::STEP_W-1:0]          step_q;
	logic                                 neg_q;
	logic [twus_pkg::REM_W-1:0]           rem_q;
	logic [twus_pkg::MAG_W-1:0]           quo_q;
	logic signed [twus_pkg::WEIGHT_W-1:0] mag_q;

	logic signed [twus_pkg::PROD_W-1:0]   abs_prod;
	logic [twus_pkg::REM_W:0]             trial;
	logic [twus_pkg::REM_W:0]             diff;
	logic                                 ge;
	logic signed [twus_pkg::WEIGHT_W-1:0] quo_ext;

	always_comb begin
		abs_prod = prod[twus_pkg::PROD_W-1] ? -prod : prod;
		trial    = {rem_q, quo_q[twus_pkg::MAG_W-1]};
		ge       = (trial >= twus_pkg::DIVISOR);
		diff     = trial - twus_pkg::DIVISOR;
		quo_ext  = {1'b0, quo_q[twus_pkg::WEIGHT_W-2:0]};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= twus_pkg::STEP_W'(twus_pkg::DIV_STEPS);
		end else if (busy_q) begin
			if (step_q != '0) begin
				step_q <= step_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= prod[twus_pkg::PROD_W-1];
			rem_q <= '0;
			quo_q <= abs_prod[twus_pkg::MAG_W-1:0];
		end else if (busy_q) begin
			if (step_q != '0) begin
				rem_q <= ge ? diff[twus_pkg::REM_W-1:0] : trial[twus_pkg::REM_W-1:0];
				quo_q <= {quo_q[twus_pkg::MAG_W-2:0], ge};
			end else begin
				mag_q <= neg_q ? -quo_ext : quo_ext;
			end
		end
	end

	assign res.done = done_q;
	assign res.mag  = mag_q;

endmodule

[sv/twus_trit_chain.sv]
// ----------------------------------------------------------------------------
// twus_trit_chain
// Systolic chain of bit-serial divide-by-3 cells. Cell k takes the quotient
// stream of cell k-1, MSB first; its final remainder is base-3 digit k.
// ----------------------------------------------------------------------------
module twus_trit_chain #(
	parameter int TRITS = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  clear,
	input  logic                                  bit_in,
	input  logic                                  bit_vld,
	output logic [TRITS-1:0][twus_pkg::DIG_W-1:0] digits
);

	logic [TRITS-1:0][twus_pkg::DIG_W-1:0] rem_q;
	logic [TRITS-2:0]                      qb_q;	// quotient bit to next cell
	logic [TRITS-2:0]                      vld_q;	// its valid tag

	for (genvar k = 0; k < TRITS; k++) begin : g_cell
		logic                      in_b;
		logic                      in_v;
		logic [2:0]                val;
		logic                      ge;
		logic [twus_pkg::DIG_W-1:0] rem_nxt;

		if (k == 0) begin : g_head
			assign in_b = bit_in;
			assign in_v = bit_vld;
		end else begin : g_link
			assign in_b = qb_q[k-1];
			assign in_v = vld_q[k-1];
		end

		always_comb begin
			val     = {rem_q[k], in_b};
			ge      = (val >= 3'd3);
			rem_nxt = ge ? 2'(val - 3'd3) : val[twus_pkg::DIG_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rem_q[k] <= '0;
			end else if (clear) begin
				rem_q[k] <= '0;
			end else if (in_v) begin
				rem_q[k] <= rem_nxt;
			end
		end

		if (k < TRITS - 1) begin : g_pipe
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[k] <= 1'b0;
				end else if (clear) begin
					vld_q[k] <= 1'b0;
				end else begin
					vld_q[k] <= in_v;
				end
			end

			always_ff @(posedge clk) begin
				qb_q[k] <= ge;
			end
		end
	end

	assign digits = rem_q;

endmodule

[sv/ternary_weight_unpack_scale_core.sv]
// ----------------------------------------------------------------------------
// ternary_weight_unpack_scale_core
// Unpacks a lane word of base-3 digits into trits and dequantized weights.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one lane word with its int8 lane
//    scale, Q8.8 page scale and valid column count (clamped to
//    TRITS_PER_WORD). in_ready is high only while no lane is in work.
//  - Result channel (out_valid/out_ready): one transfer per valid column,
//    lowest digit first, carrying column, trit and weight
//    trit * page * lane / 127 (truncated toward zero); last_flag marks the
//    final column. A zero count gives no results.
//  - The first result follows once the word has passed the first chain cell;
//    with out_ready held high the following columns come one per cycle.
//  - A lane stays in work until its last column is emitted; a zero count
//    is taken without entering work. The pace is set by the base-3 digit
//    chain, which streams the 32-bit word through its divide-by-3 cells one
//    bit per cycle. The Q16.8 product is divided by 127 in a bit-serial unit
//    that finishes well inside the digit chain's run.
//  - Receiver stall: the result register holds its transfer; digits already
//    decoded stay in the chain, so no column is lost or repeated.
//  - Reset (arst_n low): block returns to idle, no result pending.
// ----------------------------------------------------------------------------
module ternary_weight_unpack_scale_core #(
	parameter int TRITS_PER_WORD = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [twus_pkg::WORD_W-1:0]            packed_word,
	input  logic signed [twus_pkg::LANE_W-1:0]     lane_scale,
	input  logic signed [twus_pkg::PAGE_W-1:0]     page_scale,
	input  logic [twus_pkg::CNT_W-1:0]             valid_count,

	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [twus_pkg::COL_W-1:0]             column_offset,
	output logic signed [twus_pkg::TRIT_W-1:0]     trit_value,
	output logic signed [twus_pkg::WEIGHT_W-1:0]   weight_value,
	output logic                                   last_flag
);

	localparam int COL_IW  = $clog2(TRITS_PER_WORD);
	localparam int CYC_MAX = twus_pkg::WORD_W + TRITS_PER_WORD;
	localparam int CYC_W   = $clog2(CYC_MAX + 1);

	twus_pkg::state_t state_q, state_nxt;

	// lane in work
	logic [twus_pkg::WORD_W-1:0]              word_q;	// MSB feeds the chain
	logic [twus_pkg::CNT_W-1:0]               cnt_q;
	logic signed [twus_pkg::PROD_W-1:0]       prod_q;
	logic                                     start_q;	// kicks the divider
	logic [CYC_W-1:0]                         cyc_q;	// cycles since transfer
	logic [twus_pkg::COL_W-1:0]               col_q;	// next column to emit

	// result register
	logic                                     out_valid_q;
	logic [twus_pkg::COL_W-1:0]               col_out_q;
	logic signed [twus_pkg::TRIT_W-1:0]       trit_out_q;
	logic signed [twus_pkg::WEIGHT_W-1:0]     weight_out_q;
	logic                                     last_out_q;

	logic                                     in_xfer;
	logic [twus_pkg::CNT_W-1:0]               cnt_clamp;
	logic signed [twus_pkg::PROD_W-1:0]       prod_in;
	logic                                     bit_vld;
	logic                                     col_ready;
	logic                                     emit;
	logic                                     col_last;
	logic [twus_pkg::DIG_W-1:0]               digit;
	logic signed [twus_pkg::TRIT_W-1:0]       trit;
	logic signed [twus_pkg::WEIGHT_W-1:0]     weight;

	logic [TRITS_PER_WORD-1:0][twus_pkg::DIG_W-1:0] digits;
	twus_pkg::div_res_t                             div_res;

	// counts beyond TRITS_PER_WORD clamp to a full lane
	assign cnt_clamp = (valid_count > twus_pkg::CNT_W'(TRITS_PER_WORD)) ?
		twus_pkg::CNT_W'(TRITS_PER_WORD) : valid_count;

	// exact product, at most 2^22 in magnitude
	assign prod_in = twus_pkg::PROD_W'(page_scale) * twus_pkg::PROD_W'(lane_scale);

	// chain cell k holds its final digit once the word has streamed through cells 0 to k
	assign bit_vld   = (state_q == twus_pkg::ST_RUN) && (cyc_q < CYC_W'(twus_pkg::WORD_W));
	assign col_ready = (cyc_q >= CYC_W'(twus_pkg::WORD_W) + CYC_W'(col_q)) && div_res.done;
	assign col_last  = ((col_q + 1'b1) == cnt_q);
	assign digit     = digits[col_q[COL_IW-1:0]];

	// digit decode and sign of the weight
	always_comb begin
		case (digit)
			twus_pkg::DIG_POS: begin
				trit   = twus_pkg::TRIT_POS;
				weight = div_res.mag;
			end
			twus_pkg::DIG_NEG: begin
				trit   = twus_pkg::TRIT_NEG;
				weight = -div_res.mag;
			end
			default: begin
				trit   = twus_pkg::TRIT_ZERO;
				weight = '0;
			end
		endcase
	end

	// next state, handshakes
	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		emit      = 1'b0;
		case (state_q)
			twus_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (cnt_clamp != '0)) begin
					state_nxt = twus_pkg::ST_RUN;
				end
			end
			twus_pkg::ST_RUN: begin
				emit = col_ready && (!out_valid_q || out_ready);
				if (emit && col_last) begin
					state_nxt = twus_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = twus_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_xfer = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twus_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// lane control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= 1'b0;
			cyc_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= in_xfer;
			if (in_xfer) begin
				cyc_q <= '0;
				col_q <= '0;
				cnt_q <= cnt_clamp;
			end else begin
				if ((state_q == twus_pkg::ST_RUN) && (cyc_q != CYC_W'(CYC_MAX))) begin
					cyc_q <= cyc_q + 1'b1;
				end
				if (emit) begin
					col_q <= col_q + 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// lane payload and result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			word_q <= packed_word;
			prod_q <= prod_in;
		end else if (bit_vld) begin
			word_q <= {word_q[twus_pkg::WORD_W-2:0], 1'b0};
		end
		if (emit) begin
			col_out_q    <= col_q;
			trit_out_q   <= trit;
			weight_out_q <= weight;
			last_out_q   <= col_last;
		end
	end

	twus_trit_chain #(
		.TRITS (TRITS_PER_WORD)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (in_xfer),
		.bit_in  (word_q[twus_pkg::WORD_W-1]),
		.bit_vld (bit_vld),
		.digits  (digits)
	);

	twus_div127 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.prod   (prod_q),
		.res    (div_res)
	);

	assign out_valid     = out_valid_q;
	assign column_offset = col_out_q;
	assign trit_value    = trit_out_q;
	assign weight_value  = weight_out_q;
	assign last_flag     = last_out_q;

endmodule

[sv/twus_checker.sv]
// ----------------------------------------------------------------------------
// twus_checker
// Port-level checks of the ternary weight unpack block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twus_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [twus_pkg::COL_W-1:0]           column_offset,
	input logic signed [twus_pkg::TRIT_W-1:0]   trit_value,
	input logic signed [twus_pkg::WEIGHT_W-1:0] weight_value,
	input logic                                 last_flag
);

	// stalled result holds
	`TWUS_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(column_offset) && $stable(trit_value) && $stable(weight_value) && $stable(last_flag))

	// trit is -1, 0 or +1 and a zero trit carries a zero weight
	`TWUS_NEVER(a_trit_code, clk, arst_n, out_valid && (trit_value == 2'b10))
	`TWUS_ASSERT(a_zero_weight, clk, arst_n, out_valid && (trit_value == 2'b00) |-> weight_value == '0)

	// a new lane is taken only once the previous one has emitted its last column
	`TWUS_NEVER(a_lane_overlap, clk, arst_n, in_valid && in_ready && out_valid && !last_flag)

endmodule

bind ternary_weight_unpack_scale_core twus_checker u_twus_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.column_offset (column_offset),
	.trit_value    (trit_value),
	.weight_value  (weight_value),
	.last_flag     (last_flag)
);
